### rtl/core/i2cbb_pkg.sv
// Types and constants for the I2C byte-level master.
// No dependencies; imported by the master, its checker and the bench.
package i2cbb_pkg;

    localparam int DELAY_W = 16;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 4;
    localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_START = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_WRITE = 3'd3,
        REQ_READ  = 3'd4
    } req_type_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST1     = 4'd1,
        PH_ST2     = 4'd2,
        PH_ST3     = 4'd3,
        PH_ST4     = 4'd4,
        PH_SP1     = 4'd5,
        PH_SP2     = 4'd6,
        PH_SP3     = 4'd7,
        PH_WR_H    = 4'd8,
        PH_WR_L    = 4'd9,
        PH_WR_ACK  = 4'd10,
        PH_RD_WAIT = 4'd11,
        PH_RD_H    = 4'd12,
        PH_RD_L    = 4'd13,
        PH_RD_ACK  = 4'd14
    } phase_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_in;
        logic              scl_in;
    } req_t;

    typedef struct packed {
        logic              scl_release;
        logic              sda_release;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_level;
        logic              busy_res;
        logic              done_res;
    } res_t;

endpackage

### rtl/core/i2c_bitbang_master.sv
// I2C byte-level master: start, stop, write byte, read byte as line sequences.
// Depends on i2cbb_pkg (request/result structs, phase enum, command codes).
//
// Usage:
//   cfg channel  - cfg_valid/cfg_ready/cfg_data write delay_ticks, the number
//                  of ticks in one line delay interval (zero acts as one).
//                  Always ready; write only while no request is in flight.
//   req channel  - one request per time tick. req_type selects tick, start,
//                  stop, write or read; a command is taken only while idle,
//                  otherwise the request counts as a plain tick. Each request
//                  also carries the sampled sda_in and scl_in pin levels.
//   res channel  - exactly one result per request: pin drive after the
//                  request's update, last read byte, last ack bit, busy and
//                  done flags.
// Timing: a request is stepped through the phase machine in the cycle it is
//   accepted and its result is registered, valid in the following cycle;
//   throughput is one request per cycle unless a stall holds it; the single result register sets it.
// Stall: while a result waits on res_ready, req_ready drops; a new request is
//   taken in the same cycle the pending result is taken.
// Reset: idle, both lines released, ack bit 1, rx byte 0, delay_ticks 1,
//   no result pending.
module i2c_bitbang_master
    import i2cbb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DELAY_W-1:0] cfg_data,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res
);

    // controller state
    phase_t             phase_reg,     phase_next;
    logic [CNT_W-1:0]   bit_cnt_reg,   bit_cnt_next;
    logic [BYTE_W-1:0]  shift_reg,     shift_next;
    logic [DELAY_W-1:0] dly_cnt_reg,   dly_cnt_next;
    logic               ack_choice_reg, ack_choice_next;
    logic               scl_reg,       scl_next;
    logic               sda_reg,       sda_next;
    logic               ack_smp_reg,   ack_smp_next;
    logic [BYTE_W-1:0]  rx_hold_reg,   rx_hold_next;
    logic               done_next;

    logic [DELAY_W-1:0] dly_ticks_reg;
    logic [DELAY_W-1:0] dly_load;

    logic               res_valid_reg;
    res_t               res_reg;
    res_t               res_next;
    logic               accept;

    assign cfg_ready = 1'b1;
    assign req_ready = !res_valid_reg || res_ready;
    assign accept    = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a zero delay setting behaves as one tick
    assign dly_load = (dly_ticks_reg == '0) ? DELAY_W'(1) : dly_ticks_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        dly_cnt_next    = dly_cnt_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_smp_next    = ack_smp_reg;
        rx_hold_next    = rx_hold_reg;
        done_next       = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            case (req.req_type)
                REQ_START:
                begin
                    sda_next     = 1'b1;
                    dly_cnt_next = dly_load;
                    phase_next   = PH_ST1;
                end
                REQ_STOP:
                begin
                    sda_next     = 1'b0;
                    dly_cnt_next = dly_load;
                    phase_next   = PH_SP1;
                end
                REQ_WRITE:
                begin
                    // drive the MSB now, keep the rest for later bits
                    sda_next     = req.tx_byte[BYTE_W-1];
                    scl_next     = 1'b1;
                    shift_next   = {req.tx_byte[BYTE_W-2:0], 1'b0};
                    bit_cnt_next = CNT_W'(1);
                    dly_cnt_next = dly_load;
                    phase_next   = PH_WR_H;
                end
                REQ_READ:
                begin
                    ack_choice_next = req.send_ack;
                    shift_next      = '0;
                    bit_cnt_next    = '0;
                    sda_next        = 1'b1;
                    scl_next        = 1'b1;
                    phase_next      = PH_RD_WAIT;
                end
                default:
                begin
                    // plain tick or unused code: nothing to start
                end
            endcase
        end
        else if (phase_reg == PH_RD_WAIT)
        begin
            // hold until the slave lets SCL go high
            if (req.scl_in)
            begin
                dly_cnt_next = dly_load;
                phase_next   = PH_RD_H;
            end
        end
        else if (dly_cnt_reg > DELAY_W'(1))
        begin
            dly_cnt_next = dly_cnt_reg - DELAY_W'(1);
        end
        else
        begin
            dly_cnt_next = '0;
            case (phase_reg)
                PH_ST1:
                begin
                    scl_next = 1'b1;  dly_cnt_next = dly_load;  phase_next = PH_ST2;
                end
                PH_ST2:
                begin
                    sda_next = 1'b0;  dly_cnt_next = dly_load;  phase_next = PH_ST3;
                end
                PH_ST3:
                begin
                    scl_next = 1'b0;  dly_cnt_next = dly_load;  phase_next = PH_ST4;
                end
                PH_SP1:
                begin
                    scl_next = 1'b1;  dly_cnt_next = dly_load;  phase_next = PH_SP2;
                end
                PH_SP2:
                begin
                    sda_next = 1'b1;  dly_cnt_next = dly_load;  phase_next = PH_SP3;
                end
                PH_WR_H:
                begin
                    scl_next = 1'b0;  dly_cnt_next = dly_load;  phase_next = PH_WR_L;
                end
                PH_WR_L:
                begin
                    scl_next     = 1'b1;
                    dly_cnt_next = dly_load;
                    if (bit_cnt_reg < BITS_PER_BYTE)
                    begin
                        sda_next     = shift_reg[BYTE_W-1];
                        shift_next   = {shift_reg[BYTE_W-2:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                        phase_next   = PH_WR_H;
                    end
                    else
                    begin
                        // release SDA for the slave's acknowledge
                        sda_next   = 1'b1;
                        phase_next = PH_WR_ACK;
                    end
                end
                PH_WR_ACK:
                begin
                    ack_smp_next = req.sda_in;
                    scl_next     = 1'b0;
                    phase_next   = PH_IDLE;
                    done_next    = 1'b1;
                end
                PH_RD_H:
                begin
                    shift_next   = {shift_reg[BYTE_W-2:0], req.sda_in};
                    bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                    scl_next     = 1'b0;
                    dly_cnt_next = dly_load;
                    phase_next   = PH_RD_L;
                end
                PH_RD_L:
                begin
                    scl_next = 1'b1;
                    if (bit_cnt_reg < BITS_PER_BYTE)
                    begin
                        phase_next = PH_RD_WAIT;
                    end
                    else
                    begin
                        sda_next     = !ack_choice_reg;
                        dly_cnt_next = dly_load;
                        phase_next   = PH_RD_ACK;
                    end
                end
                PH_RD_ACK:
                begin
                    scl_next     = 1'b0;
                    sda_next     = 1'b1;
                    rx_hold_next = shift_reg;
                    phase_next   = PH_IDLE;
                    done_next    = 1'b1;
                end
                default:
                begin
                    // last delay of start or stop has run out
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            endcase
        end

        res_next.scl_release = scl_next;
        res_next.sda_release = sda_next;
        res_next.rx_byte     = rx_hold_next;
        res_next.ack_level   = ack_smp_next;
        res_next.busy_res    = (phase_next != PH_IDLE);
        res_next.done_res    = done_next;
    end

    // delay setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly_ticks_reg <= DELAY_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            dly_ticks_reg <= cfg_data;
        end
    end

    // advance the controller once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= '0;
            shift_reg      <= '0;
            dly_cnt_reg    <= '0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_smp_reg    <= 1'b1;
            rx_hold_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            dly_cnt_reg    <= dly_cnt_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_smp_reg    <= ack_smp_next;
            rx_hold_reg    <= rx_hold_next;
        end
    end

    // result register: load on accept, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### rtl/core/i2cbb_checker.sv
// Port-level checks for the I2C byte-level master, bound to its top level.
// Depends on i2cbb_pkg and i2c_bitbang_master.
module i2cbb_checker
    import i2cbb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    a_req_gives_res: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> res_valid)
        else $error("accepted request produced no result");

    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !req_ready)
        else $error("request taken while result stalled");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> !res.busy_res)
        else $error("done flagged while still busy");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result changed");

endmodule

bind i2c_bitbang_master i2cbb_checker u_i2cbb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

### sim/tb_top.sv
// Self-checking bench for the I2C byte-level master (i2c_bitbang_master).
// Depends on i2cbb_pkg for the request/result structs, command codes and phases.
// A directed table runs first, then random bus traffic under several delay and idling mixes.
`timescale 1ns / 1ps

module tb_top;
    import i2cbb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int N_PHASES        = 7;
    localparam int PRESSURE_PHASE  = 4;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // Block ports; every input starts at a known value
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [DELAY_W-1:0] cfg_data  = '0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    req_t               req       = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    res_t               res;

    i2c_bitbang_master DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Bench-side copy of the bus controller: register plus sequencing state
    logic [DELAY_W-1:0] bus_delay_cfg = DELAY_W'(1);
    phase_t             bus_phase     = PH_IDLE;
    logic [CNT_W-1:0]   bus_bits      = '0;
    logic [BYTE_W-1:0]  bus_shift     = '0;
    logic [DELAY_W-1:0] bus_wait      = '0;
    logic               bus_ack_pick  = 1'b0;
    logic               bus_scl       = 1'b1;
    logic               bus_sda       = 1'b1;
    logic               bus_ack_seen  = 1'b1;
    logic [BYTE_W-1:0]  bus_rx        = '0;

    // Expected pin/status words, oldest first
    res_t bus_status_q[$];

    int err_count     = 0;
    int send_gap_pct  = 0;
    int stall_pct     = 0;
    bit pressure_req  = 1'b0;
    bit pressure_taken = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    // Directed table: a request plus, where obvious, the status it must produce
    typedef struct {
        req_t r;
        bit   typed;
        res_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic res_t bus_status(input logic scl, input logic sda,
                                        input logic [BYTE_W-1:0] rx, input logic ack,
                                        input logic busy, input logic fin);
        res_t s;
        s.scl_release = scl;
        s.sda_release = sda;
        s.rx_byte     = rx;
        s.ack_level   = ack;
        s.busy_res    = busy;
        s.done_res    = fin;
        return s;
    endfunction

    // Load the delay counter (zero counts as one) and move to the next phase
    function automatic void arm_wait(input phase_t nxt);
        bus_wait  = (bus_delay_cfg == '0) ? DELAY_W'(1) : bus_delay_cfg;
        bus_phase = nxt;
    endfunction

    // Advance the controller by one tick and return the status it shows after it
    function automatic res_t next_bus_status(input req_t r);
        logic fin;
        fin = 1'b0;
        if (bus_phase == PH_IDLE) begin
            // Commands only take effect while idle; codes past READ act as ticks
            case (r.req_type)
                REQ_START: begin
                    bus_sda = 1'b1;
                    arm_wait(PH_ST1);
                end
                REQ_STOP: begin
                    bus_sda = 1'b0;
                    arm_wait(PH_SP1);
                end
                REQ_WRITE: begin
                    bus_sda   = r.tx_byte[BYTE_W-1];
                    bus_scl   = 1'b1;
                    bus_shift = r.tx_byte << 1;
                    bus_bits  = CNT_W'(1);
                    arm_wait(PH_WR_H);
                end
                REQ_READ: begin
                    bus_ack_pick = r.send_ack;
                    bus_shift    = '0;
                    bus_bits     = '0;
                    bus_sda      = 1'b1;
                    bus_scl      = 1'b1;
                    bus_phase    = PH_RD_WAIT;
                end
                default: ;
            endcase
        end else if (bus_phase == PH_RD_WAIT) begin
            // Clock stretching: hold until the slave lets SCL go high
            if (r.scl_in)
                arm_wait(PH_RD_H);
        end else if (bus_wait > 1) begin
            bus_wait--;
        end else begin
            bus_wait = '0;
            case (bus_phase)
                PH_ST1: begin bus_scl = 1'b1; arm_wait(PH_ST2); end
                PH_ST2: begin bus_sda = 1'b0; arm_wait(PH_ST3); end
                PH_ST3: begin bus_scl = 1'b0; arm_wait(PH_ST4); end
                PH_SP1: begin bus_scl = 1'b1; arm_wait(PH_SP2); end
                PH_SP2: begin bus_sda = 1'b1; arm_wait(PH_SP3); end
                PH_WR_H: begin bus_scl = 1'b0; arm_wait(PH_WR_L); end
                PH_WR_L: begin
                    if (bus_bits < BITS_PER_BYTE) begin
                        bus_sda   = bus_shift[BYTE_W-1];
                        bus_shift = bus_shift << 1;
                        bus_bits++;
                        bus_scl   = 1'b1;
                        arm_wait(PH_WR_H);
                    end else begin
                        // Release SDA for the slave and raise SCL for its acknowledge bit
                        bus_sda = 1'b1;
                        bus_scl = 1'b1;
                        arm_wait(PH_WR_ACK);
                    end
                end
                PH_WR_ACK: begin
                    bus_ack_seen = r.sda_in;
                    bus_scl      = 1'b0;
                    bus_phase    = PH_IDLE;
                    fin          = 1'b1;
                end
                PH_RD_H: begin
                    bus_shift = {bus_shift[BYTE_W-2:0], r.sda_in};
                    bus_bits++;
                    bus_scl   = 1'b0;
                    arm_wait(PH_RD_L);
                end
                PH_RD_L: begin
                    // SCL low for a full interval between read bits
                    bus_scl = 1'b1;
                    if (bus_bits < BITS_PER_BYTE) begin
                        bus_phase = PH_RD_WAIT;
                    end else begin
                        bus_sda = ~bus_ack_pick;
                        arm_wait(PH_RD_ACK);
                    end
                end
                PH_RD_ACK: begin
                    bus_scl   = 1'b0;
                    bus_sda   = 1'b1;
                    bus_rx    = bus_shift;
                    bus_phase = PH_IDLE;
                    fin       = 1'b1;
                end
                default: begin
                    // Last delay of a start or stop sequence
                    bus_phase = PH_IDLE;
                    fin       = 1'b1;
                end
            endcase
        end
        return bus_status(bus_scl, bus_sda, bus_rx, bus_ack_seen,
                          bus_phase != PH_IDLE, fin);
    endfunction

    // Random request: mostly full command sequences, some ignored commands and bad codes
    function automatic req_t pick_bus_req();
        req_t r;
        int   roll;
        r.tx_byte  = BYTE_W'($urandom_range(255));
        r.send_ack = 1'($urandom_range(1));
        r.sda_in   = 1'($urandom_range(1));
        r.scl_in   = ($urandom_range(99) < 80);
        r.req_type = REQ_TICK;
        roll = $urandom_range(99);
        if (bus_phase == PH_IDLE) begin
            if (roll < 60)
                r.req_type = 3'($urandom_range(int'(REQ_START), int'(REQ_READ)));
            else if (roll < 70)
                r.req_type = 3'($urandom_range(int'(REQ_READ) + 1, (1 << 3) - 1));
        end else begin
            if (roll < 10)
                r.req_type = 3'($urandom_range(int'(REQ_START), int'(REQ_READ)));
            else if (roll < 15)
                r.req_type = 3'($urandom_range(int'(REQ_READ) + 1, (1 << 3) - 1));
        end
        return r;
    endfunction

    task automatic add_row(input logic [2:0] kind, input logic [BYTE_W-1:0] tx,
                           input logic ack, input logic sda, input logic scl,
                           input bit typed, input res_t want);
        dir_row_t row;
        row.r.req_type = kind;
        row.r.tx_byte  = tx;
        row.r.send_ack = ack;
        row.r.sda_in   = sda;
        row.r.scl_in   = scl;
        row.typed      = typed;
        row.want       = want;
        dir_rows.push_back(row);
    endtask

    // Offer one request (after a random gap), wait for the handshake, record the expectation
    task automatic send_bus_req(input req_t r, input bit typed, input res_t want);
        res_t guess;
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        guess = next_bus_status(r);
        bus_status_q.push_back(typed ? want : guess);
    endtask

    // Tick the bus back to idle, then let every result drain before touching the register
    task automatic drain_bus();
        req_t r;
        while (bus_phase != PH_IDLE) begin
            r          = '0;
            r.req_type = REQ_TICK;
            r.scl_in   = 1'b1;
            r.sda_in   = 1'($urandom_range(1));
            send_bus_req(r, 1'b0, '0);
        end
        req_valid <= 1'b0;
        while (bus_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] ticks);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        bus_delay_cfg = ticks;
        cfg_valid <= 1'b0;
    endtask

    task automatic report_field(input string name, input logic [BYTE_W-1:0] want,
                                input logic [BYTE_W-1:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        err_count++;
    endtask

    // Result side: random stalls, plus one long hold-off when the pressure phase asks
    always @(posedge clk) begin
        if (pressure_req && !pressure_taken) begin
            pressure_taken = 1'b1;
            hold_left      = PRESSURE_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation, field by field
    always @(posedge clk) begin : res_check
        res_t want;
        if (rst_n && res_valid && res_ready) begin
            if (bus_status_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, res);
                err_count++;
            end else begin
                want = bus_status_q.pop_front();
                if (res.scl_release !== want.scl_release)
                    report_field("scl_release", BYTE_W'(want.scl_release),
                                 BYTE_W'(res.scl_release));
                if (res.sda_release !== want.sda_release)
                    report_field("sda_release", BYTE_W'(want.sda_release),
                                 BYTE_W'(res.sda_release));
                if (res.rx_byte !== want.rx_byte)
                    report_field("rx_byte", want.rx_byte, res.rx_byte);
                if (res.ack_level !== want.ack_level)
                    report_field("ack_level", BYTE_W'(want.ack_level),
                                 BYTE_W'(res.ack_level));
                if (res.busy_res !== want.busy_res)
                    report_field("busy_res", BYTE_W'(want.busy_res),
                                 BYTE_W'(res.busy_res));
                if (res.done_res !== want.done_res)
                    report_field("done_res", BYTE_W'(want.done_res),
                                 BYTE_W'(res.done_res));
            end
        end
    end

    // Watchdog: drop the run if no channel moves for too long
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no handshake for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int          plan_delay [N_PHASES] = '{1, 0, 2, 3, 4, 2, 65535};
        int          plan_gap   [N_PHASES] = '{0, 78, 0, 27, 0, 0, 0};
        int          plan_stall [N_PHASES] = '{0, 0, 78, 27, 0, 0, 0};
        int          plan_items [N_PHASES] = '{300, 250, 250, 250, 200, 200, 150};
        res_t        rest;
        req_t        r;

        rest = bus_status(1'b1, 1'b1, '0, 1'b1, 1'b0, 1'b0);

        // Idle ticks and unused codes must leave the lines released
        add_row(REQ_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, rest);
        add_row(REQ_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, rest);
        add_row(REQ_READ + 3'd1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, rest);
        add_row(REQ_READ + 3'd2, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, rest);
        add_row(REQ_READ + 3'd3, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, rest);
        // Start condition; a stop arriving mid-sequence counts as a tick
        add_row(REQ_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1,
                bus_status(1'b1, 1'b1, '0, 1'b1, 1'b1, 1'b0));
        add_row(REQ_STOP, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1,
                bus_status(1'b0, 1'b0, '0, 1'b1, 1'b0, 1'b1));
        // Stop condition
        add_row(REQ_STOP, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(REQ_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(REQ_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(REQ_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
                bus_status(1'b1, 1'b1, '0, 1'b1, 1'b0, 1'b1));
        // All-ones write; a read while busy is ignored, the first drain's ticks finish it
        add_row(REQ_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_READ, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, '0);
        repeat (6) add_row(REQ_TICK, 8'h5A, 1'b0, 1'b0, 1'b1, 1'b0, '0);

        // Hold reset, then release it on a rising edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_bus_req(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);

        // Random traffic, one delay setting and idling mix per phase
        for (int p = 0; p < N_PHASES; p++) begin
            drain_bus();
            write_delay(DELAY_W'(plan_delay[p]));
            send_gap_pct = plan_gap[p];
            stall_pct    = plan_stall[p];
            if (p == PRESSURE_PHASE)
                pressure_req = 1'b1;
            if (p == N_PHASES - 1) begin
                // Longest delay: open a start and tick partway into it
                r          = pick_bus_req();
                r.req_type = REQ_START;
                send_bus_req(r, 1'b0, '0);
            end
            repeat (plan_items[p])
                send_bus_req(pick_bus_req(), 1'b0, '0);
        end

        // Drop valid, wait out the last results, then a short settle
        req_valid <= 1'b0;
        while (bus_status_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0 && bus_status_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/i2cbb_pkg.sv
rtl/core/i2c_bitbang_master.sv
rtl/core/i2cbb_checker.sv
sim/tb_top.sv
